>>> design/rv32i_subset_execute_assert.svh
// assertion macros used by the execute unit top file
`ifndef RV32I_SUBSET_EXECUTE_ASSERT_SVH
`define RV32I_SUBSET_EXECUTE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RVX_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvx check failed");
// next-cycle implication outside reset
`define RVX_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvx check failed");
`endif

>>> design/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// shared constants and types of the rv32i subset execute unit
// ----------------------------------------------------------------------------
package rvx_pkg;
	localparam int unsigned DATA_WORDS_DEF = 4096;
	localparam logic [31:0] CONSOLE_RST = 32'h2000_0000;
	localparam logic [31:0] DATA_BASE_RST = 32'h1000_0000;
	localparam logic [6:0] OPC_LUI = 7'h37;
	localparam logic [6:0] OPC_AUIPC = 7'h17;
	localparam logic [6:0] OPC_JAL = 7'h6F;
	localparam logic [6:0] OPC_JALR = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD = 7'h03;
	localparam logic [6:0] OPC_STORE = 7'h23;
	localparam logic [6:0] OPC_IMM = 7'h13;
	localparam logic [6:0] OPC_OP = 7'h33;
	localparam logic [6:0] F7_ALT = 7'b0100000;
	localparam logic [4:0] SHAMT_MASK = 5'h1F;
	localparam logic [0:0] REG_CONSOLE = 1'b0;
	localparam logic [0:0] REG_DATA_BASE = 1'b1;
	// classified operation
	typedef enum logic [3:0] {
		K_NONE, K_LUI, K_AUIPC, K_JAL, K_JALR, K_BR, K_LOAD, K_STORE,
		K_ALU, K_PRELOAD, K_UNK
	} kind_t;
	typedef enum logic [3:0] {
		A_ADD, A_SUB, A_SLT, A_XOR, A_OR, A_AND, A_SLL, A_SRL, A_SRA, A_NOP
	} alu_op_t;
	// one decoded item passed through the queue
	typedef struct packed {
		kind_t kind;
		alu_op_t alu;
		logic use_imm;
		logic [2:0] f3;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [31:0] imm;
		logic [31:0] word;
		logic [31:0] cval;
	} dec_t;
endpackage

>>> design/rv32i_subset_execute.sv
// ----------------------------------------------------------------------------
// rv32i_subset_execute
// execute unit for an rv32i subset with a decoupled decode front and execute back
// ----------------------------------------------------------------------------
// channel   direction  handshake         payload
// in        input      in_valid/in_stall action, instruction, preload_index, console_value
// out       output     out_valid/out_stall next_pc, console_write, console_byte, console_read,
//                                          unknown_instruction
// cfg       input      apb               console_address, data_base
// one item per cycle while the output is not stalled, but for memory loads, which wait out a
// synchronous ram read. after reset the data memory is cleared word by word; the queue takes
// up to two items then, but nothing executes until the clear is done.
// a two entry queue decouples decode from execute; a stalled output holds the back part.
// ----------------------------------------------------------------------------
`include "rv32i_subset_execute_assert.svh"
module rv32i_subset_execute #(
	parameter int unsigned DATA_WORDS = rvx_pkg::DATA_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic action,
	input logic [31:0] instruction,
	input logic [11:0] preload_index,
	input logic signed [31:0] console_value,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] next_pc,
	output logic console_write,
	output logic [7:0] console_byte,
	output logic console_read,
	output logic unknown_instruction,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:2] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [31:0] console_address_q, data_base_q;
	logic q_valid, q_pop, busy, fr_stall;
	rvx_pkg::dec_t q_data;

	// configuration registers
	assign pready = 1'b1;
	assign prdata = paddr[2] == rvx_pkg::REG_DATA_BASE ? data_base_q : console_address_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			console_address_q <= rvx_pkg::CONSOLE_RST;
			data_base_q <= rvx_pkg::DATA_BASE_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == rvx_pkg::REG_CONSOLE) console_address_q <= pwdata;
			else data_base_q <= pwdata;
		end
	end

	assign in_stall = fr_stall;

	rvx_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(fr_stall),
		.action(action), .instruction(instruction), .console_value(console_value),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	rvx_back #(.DATA_WORDS(DATA_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
		.console_address(console_address_q), .data_base(data_base_q),
		.preload_index(preload_index), .in_take(in_valid && !fr_stall),
		.out_valid(out_valid), .out_stall(out_stall), .next_pc(next_pc),
		.console_write(console_write), .console_byte(console_byte),
		.console_read(console_read), .unknown_instruction(unknown_instruction),
		.busy(busy)
	);

	// checks
	`RVX_ASSERT_IMP(a_pop_needs_item, q_pop, q_valid)
	`RVX_ASSERT_IMP(a_console_one_kind, out_valid, !(console_write && console_read))
	`RVX_ASSERT_NXT(a_hold_out, out_valid && out_stall, out_valid && $stable(next_pc))
	`RVX_ASSERT_IMP(a_busy_on_out, out_valid, busy)
endmodule

>>> design/rvx_ram.sv
// ----------------------------------------------------------------------------
// rvx_ram
// generic ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module rvx_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> design/rvx_front.sv
// ----------------------------------------------------------------------------
// rvx_front
// accepts items, decodes them into an operation record and queues them
// ----------------------------------------------------------------------------
module rvx_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic action,
	input logic [31:0] instruction,
	input logic [31:0] console_value,
	output logic q_valid,
	output rvx_pkg::dec_t q_data,
	input logic q_pop
);
	rvx_pkg::dec_t dec;
	rvx_pkg::dec_t buf_q [2];
	logic rd_ptr_q, wr_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic [6:0] opc, f7;
	logic [2:0] f3;

	assign opc = instruction[6:0];
	assign f3 = instruction[14:12];
	assign f7 = instruction[31:25];

	// decode
	always_comb begin
		dec = '0;
		dec.kind = rvx_pkg::K_UNK;
		dec.alu = rvx_pkg::A_NOP;
		dec.f3 = f3;
		dec.rd = instruction[11:7];
		dec.rs1 = instruction[19:15];
		dec.rs2 = instruction[24:20];
		dec.word = instruction;
		dec.cval = console_value;
		dec.imm = {{20{instruction[31]}}, instruction[31:20]};
		if (action) begin
			dec.kind = rvx_pkg::K_PRELOAD;
		end else begin
			unique case (opc)
				rvx_pkg::OPC_LUI: begin
					dec.kind = rvx_pkg::K_LUI;
					dec.imm = {instruction[31:12], 12'd0};
				end
				rvx_pkg::OPC_AUIPC: begin
					dec.kind = rvx_pkg::K_AUIPC;
					dec.imm = {instruction[31:12], 12'd0};
				end
				rvx_pkg::OPC_JAL: begin
					dec.kind = rvx_pkg::K_JAL;
					dec.imm = {{11{instruction[31]}}, instruction[31], instruction[19:12],
						instruction[20], instruction[30:21], 1'b0};
				end
				rvx_pkg::OPC_JALR: dec.kind = rvx_pkg::K_JALR;
				rvx_pkg::OPC_BRANCH: begin
					if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd4 || f3 == 3'd5)
						dec.kind = rvx_pkg::K_BR;
					dec.imm = {{19{instruction[31]}}, instruction[31], instruction[7],
						instruction[30:25], instruction[11:8], 1'b0};
				end
				rvx_pkg::OPC_LOAD: if (f3 == 3'd2) dec.kind = rvx_pkg::K_LOAD;
				rvx_pkg::OPC_STORE: begin
					if (f3 == 3'd2) dec.kind = rvx_pkg::K_STORE;
					dec.imm = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
				end
				rvx_pkg::OPC_IMM: begin
					dec.kind = rvx_pkg::K_ALU;
					dec.use_imm = 1'b1;
					unique case (f3)
						3'd0: dec.alu = rvx_pkg::A_ADD;
						3'd2: dec.alu = rvx_pkg::A_SLT;
						3'd4: dec.alu = rvx_pkg::A_XOR;
						3'd6: dec.alu = rvx_pkg::A_OR;
						3'd7: dec.alu = rvx_pkg::A_AND;
						3'd1: dec.alu = rvx_pkg::A_SLL;
						3'd5: begin
							if (f7 == 7'd0) dec.alu = rvx_pkg::A_SRL;
							else if (f7 == rvx_pkg::F7_ALT) dec.alu = rvx_pkg::A_SRA;
							else dec.kind = rvx_pkg::K_NONE;
						end
						default: dec.kind = rvx_pkg::K_UNK;
					endcase
				end
				rvx_pkg::OPC_OP: begin
					dec.kind = rvx_pkg::K_ALU;
					if (f3 == 3'd0 && f7 == rvx_pkg::F7_ALT) dec.alu = rvx_pkg::A_SUB;
					else if (f3 == 3'd5 && f7 == rvx_pkg::F7_ALT) dec.alu = rvx_pkg::A_SRA;
					else if (f7 != 7'd0) dec.kind = rvx_pkg::K_UNK;
					else begin
						unique case (f3)
							3'd0: dec.alu = rvx_pkg::A_ADD;
							3'd1: dec.alu = rvx_pkg::A_SLL;
							3'd2: dec.alu = rvx_pkg::A_SLT;
							3'd4: dec.alu = rvx_pkg::A_XOR;
							3'd5: dec.alu = rvx_pkg::A_SRL;
							3'd6: dec.alu = rvx_pkg::A_OR;
							3'd7: dec.alu = rvx_pkg::A_AND;
							default: dec.kind = rvx_pkg::K_UNK;
						endcase
					end
				end
				default: dec.kind = rvx_pkg::K_UNK;
			endcase
		end
	end

	// two entry queue toward the back part
	assign in_stall = cnt_q[1];
	assign push = in_valid && !in_stall;
	assign q_valid = cnt_q != 2'd0;
	assign q_data = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

>>> design/rvx_back.sv
// ----------------------------------------------------------------------------
// rvx_back
// executes queued operations against registers, pc and data memory
// ----------------------------------------------------------------------------
module rvx_back #(
	parameter int unsigned DATA_WORDS = rvx_pkg::DATA_WORDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input rvx_pkg::dec_t q_data,
	output logic q_pop,
	input logic [31:0] console_address,
	input logic [31:0] data_base,
	input logic [11:0] preload_index,
	input logic in_take,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] next_pc,
	output logic console_write,
	output logic [7:0] console_byte,
	output logic console_read,
	output logic unknown_instruction,
	output logic busy
);
	localparam int unsigned AW = $clog2(DATA_WORDS);

	// preload index rides alongside the queue in a parallel fifo
	logic [11:0] pidx_q [2];
	logic pw_q, pr_q;
	logic [31:0] pidx_ext;

	logic [31:0] regs_q [32];
	logic [31:0] pc_q;
	logic [AW:0] clr_q;
	logic clearing;
	logic load_wait_q;
	logic [4:0] load_rd_q;
	logic [31:0] a, b, opb, alu, addr, rf_wdata;
	logic [4:0] rf_waddr;
	logic rf_we;
	logic [31:0] npc;
	logic cw, cr, unk;
	logic [7:0] cb;
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr, idx;
	logic [31:0] mem_rdata, mem_wdata;
	logic [31:0] off;
	logic slt, take, fire, out_free, is_load_mem;

	assign clearing = !clr_q[AW];
	assign a = q_data.rs1 == 5'd0 ? 32'd0 : regs_q[q_data.rs1];
	assign b = q_data.rs2 == 5'd0 ? 32'd0 : regs_q[q_data.rs2];
	assign opb = q_data.use_imm ? q_data.imm : b;
	assign slt = $signed(a) < $signed(opb);
	assign addr = a + q_data.imm;
	assign off = addr - data_base;
	assign idx = off[AW+1:2];
	assign is_load_mem = q_data.kind == rvx_pkg::K_LOAD && addr != console_address;
	assign pidx_ext = {20'd0, pidx_q[pr_q]};

	// alu
	always_comb begin
		case (q_data.alu)
			rvx_pkg::A_ADD: alu = a + opb;
			rvx_pkg::A_SUB: alu = a - opb;
			rvx_pkg::A_SLT: alu = {31'd0, slt};
			rvx_pkg::A_XOR: alu = a ^ opb;
			rvx_pkg::A_OR: alu = a | opb;
			rvx_pkg::A_AND: alu = a & opb;
			rvx_pkg::A_SLL: alu = a << (opb[4:0] & rvx_pkg::SHAMT_MASK);
			rvx_pkg::A_SRL: alu = a >> opb[4:0];
			rvx_pkg::A_SRA: alu = 32'($signed(a) >>> opb[4:0]);
			default: alu = '0;
		endcase
	end

	// output register is free when empty or being taken
	assign out_free = !out_valid || !out_stall;
	// a memory load issues the ram read, then finishes from the wait state once the output is free
	assign fire = q_valid && !clearing && out_free && !load_wait_q;
	assign q_pop = (fire && !is_load_mem) || (load_wait_q && out_free);

	// execute
	always_comb begin
		npc = pc_q + 32'd4;
		cw = 1'b0;
		cr = 1'b0;
		cb = '0;
		unk = 1'b0;
		rf_we = 1'b0;
		rf_waddr = q_data.rd;
		rf_wdata = alu;
		mem_we = 1'b0;
		mem_waddr = idx;
		mem_wdata = b;
		take = 1'b0;
		case (q_data.f3)
			3'd0: take = a == b;
			3'd1: take = a != b;
			3'd4: take = $signed(a) < $signed(b);
			default: take = !($signed(a) < $signed(b));
		endcase
		unique case (q_data.kind)
			rvx_pkg::K_LUI: begin rf_we = 1'b1; rf_wdata = q_data.imm; end
			rvx_pkg::K_AUIPC: begin rf_we = 1'b1; rf_wdata = pc_q + q_data.imm; end
			rvx_pkg::K_JAL: begin
				rf_we = 1'b1; rf_wdata = pc_q + 32'd4; npc = pc_q + q_data.imm;
			end
			rvx_pkg::K_JALR: begin
				rf_we = 1'b1; rf_wdata = pc_q + 32'd4; npc = {addr[31:1], 1'b0};
			end
			rvx_pkg::K_BR: if (take) npc = pc_q + q_data.imm;
			rvx_pkg::K_LOAD: begin
				if (!is_load_mem) begin
					rf_we = 1'b1; rf_wdata = q_data.cval; cr = 1'b1;
				end
			end
			rvx_pkg::K_STORE: begin
				if (addr == console_address) begin
					cw = 1'b1; cb = b[7:0];
				end else mem_we = 1'b1;
			end
			rvx_pkg::K_ALU: rf_we = 1'b1;
			rvx_pkg::K_PRELOAD: begin
				npc = pc_q; mem_we = 1'b1; mem_wdata = q_data.word;
				mem_waddr = pidx_ext[AW-1:0];
			end
			rvx_pkg::K_UNK: unk = 1'b1;
			default: ;
		endcase
		if (clearing) begin
			mem_we = 1'b1; mem_waddr = clr_q[AW-1:0]; mem_wdata = '0;
		end else if (!fire || is_load_mem) begin
			mem_we = 1'b0;
		end
	end
	assign mem_raddr = idx;

	rvx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (in_take) pidx_q[pw_q] <= preload_index;
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) regs_q[i] <= '0;
			pc_q <= '0;
			clr_q <= '0;
			load_wait_q <= 1'b0;
			load_rd_q <= '0;
			out_valid <= 1'b0;
			next_pc <= '0;
			console_write <= 1'b0;
			console_byte <= '0;
			console_read <= 1'b0;
			unknown_instruction <= 1'b0;
			pw_q <= 1'b0;
			pr_q <= 1'b0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			if (in_take) pw_q <= !pw_q;
			if (q_pop) pr_q <= !pr_q;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (load_wait_q && out_free) begin
				load_wait_q <= 1'b0;
				if (load_rd_q != 5'd0) regs_q[load_rd_q] <= mem_rdata;
				pc_q <= pc_q + 32'd4;
				out_valid <= 1'b1;
				next_pc <= pc_q + 32'd4;
				console_write <= 1'b0;
				console_byte <= '0;
				console_read <= 1'b0;
				unknown_instruction <= 1'b0;
			end else if (fire && is_load_mem) begin
				load_wait_q <= 1'b1;
				load_rd_q <= q_data.rd;
			end else if (fire) begin
				if (rf_we && rf_waddr != 5'd0) regs_q[rf_waddr] <= rf_wdata;
				pc_q <= npc;
				out_valid <= 1'b1;
				next_pc <= npc;
				console_write <= cw;
				console_byte <= cb;
				console_read <= cr;
				unknown_instruction <= unk;
			end
		end
	end

	assign busy = q_valid || load_wait_q || out_valid;
endmodule
